[design/dism_pkg.sv]
// Shared types and result codes for the dirty interval set merger.
package dism_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One stored interval: inclusive start, exclusive end.
    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } interval_t;

endpackage

[design/dism_ram.sv]
// Interval table memory: one write port, one read port with registered read data.
module dism_ram #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  dism_pkg::interval_t                 wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output dism_pkg::interval_t                 rdata
);
    import dism_pkg::*;

    interval_t mem [DEPTH];
    interval_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dirty_interval_set_merger_core.sv]
// Top level of the dirty interval set merger: table sequencer, valid bits and stream ports.
//
// Each accepted span is checked against the capacity register and then merged into a table
// of up to MAX_INTERVALS disjoint intervals held in a one-port-read, one-port-write memory.
// A mark that reaches the table is handled in steps: a sequential walk with one read per
// table entry, each entry evaluated as its read data returns, a write-back step, a finish
// step that hands the result to the output register, and a return to idle, where the next
// mark is accepted. A zero-length or out-of-range mark skips the walk and the write-back.
// The input is taken only between marks; the output register holds a finished result while
// the next mark is already accepted, and a mark whose result finds that register still full
// waits until the pending beat is taken.
// Capacity writes are always ready and should be issued only while the block is idle.
module dirty_interval_set_merger_core #(
    parameter int MAX_INTERVALS = 16,
    parameter int POS_BITS      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Capacity register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Mark stream. tdata fields, low bit up: span_start[31:0], span_length[31:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // Result stream. tdata fields, low bit up: status[1:0], is_clean[0],
    // interval_count[4:0], merged_start[31:0], merged_end[31:0].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata
);
    import dism_pkg::*;

    localparam int IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CntW = $clog2(MAX_INTERVALS + 1);
    localparam logic [63:0] PosMask64 = (64'd1 << POS_BITS) - 64'd1;
    localparam logic [31:0] PosMask   = PosMask64[31:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [31:0]              capacity_reg;
    logic [MAX_INTERVALS-1:0] used_reg;
    logic [CntW-1:0]          count_reg;

    logic [31:0]              start_reg;
    logic [31:0]              end_reg;
    logic [31:0]              lo_acc_reg;
    logic [31:0]              hi_acc_reg;
    logic [MAX_INTERVALS-1:0] touch_reg;
    logic [CntW-1:0]          touch_cnt_reg;
    logic                     slot_found_reg;
    logic [IdxW-1:0]          slot_reg;
    logic [CntW-1:0]          rd_cnt_reg;
    logic                     eval_valid_reg;
    logic [IdxW-1:0]          eval_idx_reg;

    status_t                  res_status_reg;
    logic [31:0]              res_start_reg;
    logic [31:0]              res_end_reg;
    logic [CntW-1:0]          res_count_reg;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic                     out_clean_reg;
    logic [4:0]               out_count_reg;
    logic [31:0]              out_start_reg;
    logic [31:0]              out_end_reg;

    // Accept-side decode.
    logic [31:0] in_start;
    logic [31:0] in_length;
    logic [32:0] in_end;
    logic        in_accept;

    assign in_start  = s_axis_tdata[31:0] & PosMask;
    assign in_length = s_axis_tdata[63:32] & PosMask;
    assign in_end    = {1'b0, in_start} + {1'b0, in_length};
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Table memory ports.
    logic            ram_we;
    logic [IdxW-1:0] ram_waddr;
    interval_t       ram_wdata;
    logic            ram_re;
    logic [IdxW-1:0] ram_raddr;
    interval_t       ram_rdata;

    assign ram_re    = (state_reg == ST_SCAN) && (rd_cnt_reg < CntW'(MAX_INTERVALS));
    assign ram_raddr = rd_cnt_reg[IdxW-1:0];
    assign ram_we    = (state_reg == ST_WRITE) && slot_found_reg;
    assign ram_waddr = slot_reg;
    assign ram_wdata = '{hi: hi_acc_reg, lo: lo_acc_reg};

    dism_ram #(
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Evaluation of the entry whose read data has just returned. The overlap test uses the
    // original span, not the growing union.
    logic e_used;
    logic e_touch;
    logic e_take_slot;
    logic scan_last;

    assign e_used      = used_reg[eval_idx_reg];
    assign e_touch     = eval_valid_reg && e_used && (ram_rdata.hi >= start_reg)
                         && (ram_rdata.lo <= end_reg);
    assign e_take_slot = eval_valid_reg && (!e_used || e_touch) && !slot_found_reg;
    assign scan_last   = eval_valid_reg && (eval_idx_reg == IdxW'(MAX_INTERVALS - 1));

    // Table update after the merge.
    logic [MAX_INTERVALS-1:0] used_next;
    logic [CntW-1:0]          count_next;

    assign used_next  = (used_reg & ~touch_reg) | (MAX_INTERVALS'(1) << slot_reg);
    assign count_next = count_reg - touch_cnt_reg + CntW'(1);

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= '0;
            used_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            eval_valid_reg <= 1'b0;
            rd_cnt_reg     <= '0;
            slot_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end

            // A beat taken while the next result is loaded is replaced in the finish step.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        start_reg      <= in_start;
                        end_reg        <= in_end[31:0];
                        lo_acc_reg     <= in_start;
                        hi_acc_reg     <= in_end[31:0];
                        touch_reg      <= '0;
                        touch_cnt_reg  <= '0;
                        slot_found_reg <= 1'b0;
                        rd_cnt_reg     <= '0;
                        eval_valid_reg <= 1'b0;
                        res_start_reg  <= '0;
                        res_end_reg    <= '0;
                        res_count_reg  <= count_reg;
                        priority if (in_length == '0)
                        begin
                            res_status_reg <= STATUS_OK;
                            state_reg      <= ST_FINISH;
                        end
                        else if (in_end > {1'b0, capacity_reg})
                        begin
                            res_status_reg <= STATUS_RANGE;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (ram_re)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CntW'(1);
                    end
                    eval_valid_reg <= ram_re;
                    eval_idx_reg   <= ram_raddr;
                    if (e_touch)
                    begin
                        touch_reg[eval_idx_reg] <= 1'b1;
                        touch_cnt_reg           <= touch_cnt_reg + CntW'(1);
                        if (ram_rdata.lo < lo_acc_reg)
                        begin
                            lo_acc_reg <= ram_rdata.lo;
                        end
                        if (ram_rdata.hi > hi_acc_reg)
                        begin
                            hi_acc_reg <= ram_rdata.hi;
                        end
                    end
                    if (e_take_slot)
                    begin
                        slot_found_reg <= 1'b1;
                        slot_reg       <= eval_idx_reg;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end

                ST_WRITE:
                begin
                    // A touching entry always frees a slot, so no slot means no overlap.
                    if (slot_found_reg)
                    begin
                        used_reg       <= used_next;
                        count_reg      <= count_next;
                        res_status_reg <= STATUS_OK;
                        res_start_reg  <= lo_acc_reg;
                        res_end_reg    <= hi_acc_reg;
                        res_count_reg  <= count_next;
                    end
                    else
                    begin
                        res_status_reg <= STATUS_FULL;
                    end
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_clean_reg  <= (res_count_reg == '0);
                        out_count_reg  <= 5'(res_count_reg);
                        out_start_reg  <= res_start_reg;
                        out_end_reg    <= res_end_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_end_reg, out_start_reg, out_count_reg, out_clean_reg,
                            out_status_reg};

`ifndef SYNTHESIS
    // The fill count always matches the valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(count_reg))
        else $error("interval count does not match valid bits");

    // A write-back never lands on an entry that stays in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!used_reg[ram_waddr] || touch_reg[ram_waddr]))
        else $error("merged interval overwrites a live entry");

    // The entry just written is marked valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> used_reg[$past(ram_waddr)])
        else $error("written entry not marked valid");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench for the dirty interval set merger core.
module testbench;
    import dism_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_GAP     = 18;
    localparam int RANDOM_MARKS = 1900;

    typedef struct {
        status_t     status;
        bit          is_clean;
        bit [4:0]    interval_count;
        bit [31:0]   merged_start;
        bit [31:0]   merged_end;
    } mark_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // span_start[31:0], span_length[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // status, is_clean, interval_count, merged_start, merged_end

    // Shadow copy of the interval table and the capacity register.
    bit [31:0] shadow_lo [TABLE_DEPTH];
    bit [31:0] shadow_hi [TABLE_DEPTH];
    bit        shadow_used [TABLE_DEPTH];
    bit [31:0] shadow_capacity;

    mark_result_t pending_results [$];
    int  error_count;
    int  result_index;
    int  random_marks;
    bit  tx_idle;
    bit  rx_idle;
    bit [31:0] window_top;

    dirty_interval_set_merger_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one mark to the shadow table and returns the result it should produce.
    function automatic mark_result_t merge_mark(input bit [31:0] start, input bit [31:0] len);
        mark_result_t r;
        bit [32:0] span_end;
        bit [32:0] lo;
        bit [32:0] hi;
        bit touch;
        bit has_free;
        int used_count;
        r.status       = STATUS_OK;
        r.merged_start = '0;
        r.merged_end   = '0;
        span_end = {1'b0, start} + {1'b0, len};
        touch    = 1'b0;
        has_free = 1'b0;
        if (len != 0 && span_end > {1'b0, shadow_capacity})
            r.status = STATUS_RANGE;
        else if (len != 0)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (shadow_used[i] && {1'b0, shadow_hi[i]} >= {1'b0, start}
                    && {1'b0, shadow_lo[i]} <= span_end)
                    touch = 1'b1;
                if (!shadow_used[i])
                    has_free = 1'b1;
            end
            if (!touch && !has_free)
                r.status = STATUS_FULL;
            else
            begin
                lo = {1'b0, start};
                hi = span_end;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (shadow_used[i] && {1'b0, shadow_hi[i]} >= {1'b0, start}
                        && {1'b0, shadow_lo[i]} <= span_end)
                    begin
                        if ({1'b0, shadow_lo[i]} < lo)
                            lo = {1'b0, shadow_lo[i]};
                        if ({1'b0, shadow_hi[i]} > hi)
                            hi = {1'b0, shadow_hi[i]};
                        shadow_used[i] = 1'b0;
                    end
                end
                // The union goes into the lowest free slot.
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!shadow_used[i])
                    begin
                        shadow_lo[i]   = lo[31:0];
                        shadow_hi[i]   = hi[31:0];
                        shadow_used[i] = 1'b1;
                        break;
                    end
                end
                r.merged_start = lo[31:0];
                r.merged_end   = hi[31:0];
            end
        end
        used_count = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (shadow_used[i])
                used_count++;
        r.interval_count = used_count[4:0];
        r.is_clean       = (used_count == 0);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("result %0d: %s is %0h, expected %0h", result_index, what, got, want);
        error_count++;
    endtask

    // Sends one mark; tvalid stays high into the next mark when no gap is drawn.
    task automatic send_mark(input bit [31:0] start, input bit [31:0] len);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, start};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(merge_mark(start, len));
    endtask

    // Drops tvalid and waits until every result is back and the block is quiet.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input bit [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        shadow_capacity = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_zero_capacity();
        write_capacity(32'd0);
        send_mark(32'd0, 32'd1);
        send_mark(32'hFFFF_FFFF, 32'd0);
    endtask

    // Sixteen separated single-element marks fill the table; a lone mark then overflows it.
    task automatic test_table_full();
        write_capacity(32'd64);
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_mark(32'(2 * k), 32'd1);
        send_mark(32'd40, 32'd1);
        send_mark(32'd1, 32'd1);
        send_mark(32'd60, 32'd4);
        send_mark(32'd60, 32'd5);
        send_mark(32'd0, 32'd64);
        window_top = 32'd64;
    endtask

    task automatic test_full_range();
        write_capacity(32'hFFFF_FFFF);
        send_mark(32'hFFFF_FFFE, 32'd1);
        send_mark(32'hFFFF_FFFF, 32'd1);
        send_mark(32'h8000_0000, 32'h8000_0000);
    endtask

    // Each phase raises the capacity over a fresh window, marks inside it and then
    // sweeps everything below the window top into one interval.
    task automatic test_random_phases();
        bit [31:0] base;
        bit [31:0] width;
        bit [31:0] start;
        bit [31:0] len;
        int marks;
        int pick;
        while (random_marks < RANDOM_MARKS)
        begin
            base  = window_top + $urandom_range(2, 40);
            width = ($urandom_range(0, 3) == 0) ? $urandom_range(400, 3000)
                                                : $urandom_range(24, 200);
            write_capacity(base + width);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            marks   = $urandom_range(60, 140);
            for (int n = 0; n < marks; n++)
            begin
                pick  = $urandom_range(0, 99);
                start = base + $urandom_range(0, width - 1);
                if (pick < 80)
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, width / 4)
                                                      : $urandom_range(1, 4);
                else if (pick < 86)
                begin
                    start = $urandom();
                    len   = 32'd0;
                end
                else if (pick < 92)
                    len = base + width - start + $urandom_range(1, 8);
                else
                begin
                    start = $urandom();
                    len   = $urandom();
                end
                send_mark(start, len);
                random_marks++;
            end
            send_mark(32'd0, base + width);
            window_top = base + width;
        end
    endtask

    initial
    begin : result_checker
        int stall;
        mark_result_t want;
        logic [71:0] beat;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            beat = m_axis_tdata;
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result beat", beat[31:0], 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (beat[1:0] !== want.status)
                    flag_mismatch("status", 32'(beat[1:0]), 32'(want.status));
                if (beat[2] !== want.is_clean)
                    flag_mismatch("is_clean", 32'(beat[2]), 32'(want.is_clean));
                if (beat[7:3] !== want.interval_count)
                    flag_mismatch("interval_count", 32'(beat[7:3]),
                                  32'(want.interval_count));
                if (beat[39:8] !== want.merged_start)
                    flag_mismatch("merged_start", beat[39:8], want.merged_start);
                if (beat[71:40] !== want.merged_end)
                    flag_mismatch("merged_end", beat[71:40], want.merged_end);
            end
            result_index++;
        end
    end

    initial
    begin
        #(64'd24_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        error_count     = 0;
        result_index    = 0;
        random_marks    = 0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        window_top      = '0;
        shadow_capacity = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_used[i] = 1'b0;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_capacity();
        test_table_full();
        test_full_range();
        test_random_phases();

        wait_idle();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

[dirty_interval_set_merger_core.f]
design/dism_pkg.sv
design/dism_ram.sv
design/dirty_interval_set_merger_core.sv
sim/testbench.sv
